// File: hw/rtl/liv_pkg.sv
// shared constants, types and helpers for the luma inversion pipeline
`default_nettype none

package liv_pkg;

    localparam int FRAC_BITS = 16;

    // forward coefficients, round(c * 2^16), all positive magnitudes
    localparam logic [15:0] K_YR = 16'd19595;
    localparam logic [15:0] K_YG = 16'd38470;
    localparam logic [15:0] K_YB = 16'd7471;
    localparam logic [15:0] K_UR = 16'd9642;
    localparam logic [15:0] K_UG = 16'd18931;
    localparam logic [15:0] K_UB = 16'd28574;
    localparam logic [15:0] K_VR = 16'd40305;
    localparam logic [15:0] K_VG = 16'd33750;
    localparam logic [15:0] K_VB = 16'd6554;

    // inverse coefficients, signed so they multiply against signed chroma
    localparam logic signed [18:0] K_RV = 19'sd74700;
    localparam logic signed [18:0] K_GU = 19'sd25864;
    localparam logic signed [18:0] K_GV = 19'sd38050;
    localparam logic signed [18:0] K_BU = 19'sd133176;

    localparam logic signed [27:0] CHROMA_OFF = 28'sd8388608;  // 128 << 16

    typedef logic signed [27:0] t_fix;

    typedef struct packed {
        logic       vld;
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } t_yuv;

    // floor to integer, then saturate to a byte
    function automatic logic [7:0] to_byte(input t_fix fixed);
        logic signed [11:0] whole;
        whole = 12'(fixed >>> FRAC_BITS);
        if (whole < 12'sd0) begin
            to_byte = 8'd0;
        end else if (whole > 12'sd255) begin
            to_byte = 8'd255;
        end else begin
            to_byte = whole[7:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/luma_invert_via_yuv.sv
// top level: pixel luma inversion through yuv, four stage pipeline
// a word taken in passes through the four register stages before it reaches the outputs
// throughput: one word per cycle, set by the four fully pipelined stages
// busy stays low; the receiver cannot stall and nothing is held back
// reset (synchronous, active low) clears only the valid bits of each stage
`default_nettype none

module luma_invert_via_yuv (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] i_red_in,
    input  wire logic [7:0] i_green_in,
    input  wire logic [7:0] i_blue_in,
    input  wire logic [7:0] i_alpha_in,
    input  wire logic       i_last_in,
    output logic            o_valid,
    output logic [7:0]      o_red_out,
    output logic [7:0]      o_green_out,
    output logic [7:0]      o_blue_out,
    output logic [7:0]      o_alpha_out,
    output logic            o_last_out
);

    localparam int DEPTH = 4;

    liv_pkg::t_yuv yuv;
    logic [7:0]    r_alpha [DEPTH];
    logic          r_last  [DEPTH];

    assign busy = 1'b0;

    liv_fwd u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_yuv   (yuv)
    );

    liv_inv u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_yuv   (yuv),
        .o_vld   (o_valid),
        .o_red   (o_red_out),
        .o_green (o_green_out),
        .o_blue  (o_blue_out)
    );

    // sideband delay line matched to the color path
    always_ff @(posedge i_clk) begin
        r_alpha[0] <= i_alpha_in;
        r_last[0]  <= i_last_in;
        for (int i = 1; i < DEPTH; i++) begin
            r_alpha[i] <= r_alpha[i-1];
            r_last[i]  <= r_last[i-1];
        end
    end

    assign o_alpha_out = r_alpha[DEPTH-1];
    assign o_last_out  = r_last[DEPTH-1];

endmodule

`default_nettype wire

// File: hw/rtl/liv_fwd.sv
// rgb to yuv conversion with luma inversion, two register stages
`default_nettype none

module liv_fwd (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [7:0]    i_red,
    input  wire logic [7:0]    i_green,
    input  wire logic [7:0]    i_blue,
    output liv_pkg::t_yuv      o_yuv
);

    logic        r_vld1;
    logic [23:0] r_yr, r_yg, r_yb;
    logic [23:0] r_ur, r_ug, r_ub;
    logic [23:0] r_vr, r_vg, r_vb;
    logic [23:0] n_yr, n_yg, n_yb;
    logic [23:0] n_ur, n_ug, n_ub;
    logic [23:0] n_vr, n_vg, n_vb;

    liv_pkg::t_fix sum_y, sum_u, sum_v;
    liv_pkg::t_yuv r_yuv, n_yuv;

    // stage 1: constant products
    always_comb begin
        n_yr = liv_pkg::K_YR * i_red;
        n_yg = liv_pkg::K_YG * i_green;
        n_yb = liv_pkg::K_YB * i_blue;
        n_ur = liv_pkg::K_UR * i_red;
        n_ug = liv_pkg::K_UG * i_green;
        n_ub = liv_pkg::K_UB * i_blue;
        n_vr = liv_pkg::K_VR * i_red;
        n_vg = liv_pkg::K_VG * i_green;
        n_vb = liv_pkg::K_VB * i_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
        r_yr <= n_yr;
        r_yg <= n_yg;
        r_yb <= n_yb;
        r_ur <= n_ur;
        r_ug <= n_ug;
        r_ub <= n_ub;
        r_vr <= n_vr;
        r_vg <= n_vg;
        r_vb <= n_vb;
    end

    // stage 2: sums, floor and clamp, then invert luma
    always_comb begin
        sum_y = $signed({4'd0, r_yr}) + $signed({4'd0, r_yg}) + $signed({4'd0, r_yb});
        sum_u = liv_pkg::CHROMA_OFF - $signed({4'd0, r_ur}) - $signed({4'd0, r_ug})
              + $signed({4'd0, r_ub});
        sum_v = liv_pkg::CHROMA_OFF + $signed({4'd0, r_vr}) - $signed({4'd0, r_vg})
              - $signed({4'd0, r_vb});
        n_yuv.vld = r_vld1;
        n_yuv.y   = 8'd255 - liv_pkg::to_byte(sum_y);
        n_yuv.u   = liv_pkg::to_byte(sum_u);
        n_yuv.v   = liv_pkg::to_byte(sum_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yuv.vld <= 1'b0;
        end else begin
            r_yuv.vld <= n_yuv.vld;
        end
        r_yuv.y <= n_yuv.y;
        r_yuv.u <= n_yuv.u;
        r_yuv.v <= n_yuv.v;
    end

    assign o_yuv = r_yuv;

endmodule

`default_nettype wire

// File: hw/rtl/liv_inv.sv
// yuv back to rgb, two register stages
`default_nettype none

module liv_inv (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire liv_pkg::t_yuv i_yuv,
    output logic               o_vld,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);

    logic signed [8:0] du, dv;
    logic              r_vld3;
    liv_pkg::t_fix     r_yb, r_rv, r_gu, r_gv, r_bu;
    liv_pkg::t_fix     n_yb, n_rv, n_gu, n_gv, n_bu;
    liv_pkg::t_fix     sum_r, sum_g, sum_b;
    logic              r_vld4;
    logic [7:0]        r_red, r_green, r_blue;

    // stage 3: chroma differences times inverse coefficients
    always_comb begin
        du   = $signed({1'b0, i_yuv.u}) - 9'sd128;
        dv   = $signed({1'b0, i_yuv.v}) - 9'sd128;
        n_yb = $signed({4'd0, i_yuv.y, 16'd0});
        n_rv = liv_pkg::K_RV * dv;
        n_gu = liv_pkg::K_GU * du;
        n_gv = liv_pkg::K_GV * dv;
        n_bu = liv_pkg::K_BU * du;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= i_yuv.vld;
        end
        r_yb <= n_yb;
        r_rv <= n_rv;
        r_gu <= n_gu;
        r_gv <= n_gv;
        r_bu <= n_bu;
    end

    // stage 4: sums, floor and clamp
    always_comb begin
        sum_r = r_yb + r_rv;
        sum_g = r_yb - r_gu - r_gv;
        sum_b = r_yb + r_bu;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else begin
            r_vld4 <= r_vld3;
        end
        r_red   <= liv_pkg::to_byte(sum_r);
        r_green <= liv_pkg::to_byte(sum_g);
        r_blue  <= liv_pkg::to_byte(sum_b);
    end

    assign o_vld   = r_vld4;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire

// File: tb/sv/luma_invert_via_yuv_tb.sv
// self-checking testbench for the luma inversion pixel pipeline
module luma_invert_via_yuv_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pixel_t;

    // holds the inverted pixels still owed by the pipeline, oldest first
    class pixel_scoreboard;
        pixel_t inverted_q[$];
        int     errors;

        // floor of a 16-bit fraction value, then saturate to a byte
        function automatic logic [7:0] sat_byte(longint fx);
            longint whole;
            whole = fx >>> 16;
            if (whole < 0) return 8'd0;
            if (whole > 255) return 8'd255;
            return whole[7:0];
        endfunction

        function automatic pixel_t invert_luma(pixel_t px);
            longint r, g, b, y, u, v, du, dv, yf;
            pixel_t res;
            r = px.red;
            g = px.green;
            b = px.blue;
            y = sat_byte(19595 * r + 38470 * g + 7471 * b);
            u = sat_byte(-9642 * r - 18931 * g + 28574 * b + 128 * 65536);
            v = sat_byte(40305 * r - 33750 * g - 6554 * b + 128 * 65536);
            du = u - 128;
            dv = v - 128;
            yf = (255 - y) * 65536;
            res.red   = sat_byte(yf + 74700 * dv);
            res.green = sat_byte(yf - 25864 * du - 38050 * dv);
            res.blue  = sat_byte(yf + 133176 * du);
            res.alpha = px.alpha;
            res.last  = px.last;
            return res;
        endfunction

        function void note_input(pixel_t px);
            inverted_q.push_back(invert_luma(px));
        endfunction

        task report(string what, int got, int want);
            // keep the log short on a badly broken run
            if (errors < 40)
                $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(pixel_t got);
            pixel_t want;
            if (inverted_q.size() == 0) begin
                report("word with nothing pending, red", got.red, -1);
                return;
            end
            want = inverted_q.pop_front();
            if (got.red !== want.red) report("red", got.red, want.red);
            if (got.green !== want.green) report("green", got.green, want.green);
            if (got.blue !== want.blue) report("blue", got.blue, want.blue);
            if (got.alpha !== want.alpha) report("alpha", got.alpha, want.alpha);
            if (got.last !== want.last) report("last", got.last, want.last);
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] i_red_in = 8'd0;
    logic [7:0] i_green_in = 8'd0;
    logic [7:0] i_blue_in = 8'd0;
    logic [7:0] i_alpha_in = 8'd0;
    logic       i_last_in = 1'b0;
    logic       o_valid;
    logic [7:0] o_red_out;
    logic [7:0] o_green_out;
    logic [7:0] o_blue_out;
    logic [7:0] o_alpha_out;
    logic       o_last_out;

    pixel_scoreboard sb;

    luma_invert_via_yuv uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .i_alpha_in  (i_alpha_in),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_alpha_out (o_alpha_out),
        .o_last_out  (o_last_out)
    );

    always #4 i_clk = ~i_clk;

    // both sides sampled at the rising edge, inputs only move on the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && busy === 1'b0)
            sb.note_input({i_red_in, i_green_in, i_blue_in, i_alpha_in, i_last_in});
        if (i_rst_n && o_valid === 1'b1)
            sb.check_result({o_red_out, o_green_out, o_blue_out, o_alpha_out, o_last_out});
    end

    function automatic logic [7:0] pick_byte(int mode);
        case (mode)
            1: return 8'($urandom_range(0, 3));
            2: return 8'($urandom_range(252, 255));
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     mode;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            px.red   = 8'($urandom);
            px.green = 8'($urandom);
            px.blue  = 8'($urandom);
        end else if (mode < 8) begin
            // near-gray pixels keep chroma close to the offset
            px.red   = 8'($urandom);
            px.green = px.red + 8'($urandom_range(0, 6)) - 8'd3;
            px.blue  = px.red + 8'($urandom_range(0, 6)) - 8'd3;
        end else begin
            // saturated corners pick each channel from near 0 or near 255
            px.red   = pick_byte($urandom_range(1, 2));
            px.green = pick_byte($urandom_range(1, 2));
            px.blue  = pick_byte($urandom_range(1, 2));
        end
        px.alpha = 8'($urandom);
        px.last  = ($urandom_range(0, 15) == 0);
        return px;
    endfunction

    task automatic send_pixel(pixel_t px);
        @(negedge i_clk);
        start      <= 1'b1;
        i_red_in   <= px.red;
        i_green_in <= px.green;
        i_blue_in  <= px.blue;
        i_alpha_in <= px.alpha;
        i_last_in  <= px.last;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic send_rgba(int r, int g, int b, int a, int l);
        send_pixel({8'(r), 8'(g), 8'(b), 8'(a), 1'(l)});
    endtask

    // gap cycles carry junk on the data ports with start low
    task automatic hold_off(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_red_in   <= 8'($urandom);
            i_green_in <= 8'($urandom);
            i_blue_in  <= 8'($urandom);
            i_alpha_in <= 8'($urandom);
            i_last_in  <= 1'($urandom);
        end
    endtask

    task automatic drain();
        hold_off(1);
        while (sb.inverted_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("luma_invert_via_yuv_tb NOT OK");
        $finish;
    end

    initial begin
        int burst;
        int gap;
        int sent;
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        hold_off(2);

        send_rgba(0, 0, 0, 0, 0);
        send_rgba(255, 255, 255, 255, 1);
        send_rgba(255, 0, 0, 8'h55, 0);
        send_rgba(0, 255, 0, 8'hAA, 1);
        send_rgba(0, 0, 255, 8'h0F, 0);
        send_rgba(255, 255, 0, 8'hF0, 0);
        send_rgba(0, 255, 255, 1, 0);
        send_rgba(255, 0, 255, 8'h80, 1);
        send_rgba(128, 128, 128, 8'h7F, 0);
        send_rgba(1, 1, 1, 8'hFE, 0);
        send_rgba(254, 254, 254, 1, 1);
        send_rgba(16, 235, 16, 8'h33, 0);
        send_rgba(235, 16, 235, 8'hCC, 0);
        send_rgba(127, 128, 129, 8'h5A, 0);
        send_rgba(0, 128, 255, 8'hA5, 1);
        send_rgba(255, 128, 0, 8'h3C, 0);
        send_rgba(0, 0, 128, 8'hC3, 0);
        send_rgba(128, 0, 0, 8'h96, 1);
        drain();

        sent = 0;
        while (sent < 1650) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                send_pixel(rand_pixel());
                sent++;
            end
            if ($urandom_range(0, 19) == 0) begin
                drain();
            end else begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                hold_off(gap);
            end
        end
        drain();
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0)
            $display("luma_invert_via_yuv_tb OK");
        else
            $display("luma_invert_via_yuv_tb NOT OK");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/liv_pkg.sv
hw/rtl/liv_fwd.sv
hw/rtl/liv_inv.sv
hw/rtl/luma_invert_via_yuv.sv
tb/sv/luma_invert_via_yuv_tb.sv
